>>> rtl/avr_pkg.sv
`timescale 1ns / 1ps

package avr_pkg;

    localparam int THR_W      = 17;
    localparam int TAG_W      = 24;
    localparam int LIMB_W     = 34;
    localparam int PROD_W     = 2 * LIMB_W;
    localparam int ACC_W      = 5 * LIMB_W;
    localparam int SH_W       = 3;
    localparam int PC_W       = 5;
    localparam int LHS_SHIFT  = 32;

    localparam logic [THR_W-1:0] COS_THR_RESET = 17'd65287;

    localparam logic CFG_KEEP_MODE     = 1'b0;
    localparam logic CFG_COS_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        K_MUL,
        K_NOP,
        K_DONE
    } t_kind;

    typedef enum logic [3:0] {
        S_UM, S_VM,
        S_D0, S_D1,
        S_U0, S_U1,
        S_V0, S_V1,
        S_T,  S_TT,
        S_R0, S_R1, S_R2
    } t_src;

    typedef enum logic [2:0] {
        D_NONE,
        D_DOT,
        D_UU,
        D_VV,
        D_TT,
        D_LHS,
        D_RR
    } t_dst;

    typedef struct packed {
        t_kind            kind;
        t_src             a;
        t_src             b;
        logic [1:0]       k;
        logic [SH_W-1:0]  sh;
        logic             sgn;
        logic             clr;
        t_dst             dst;
    } t_uop;

    typedef struct packed {
        logic              en;
        logic              clr;
        logic              sub;
        logic [SH_W-1:0]   sh;
        logic [LIMB_W-1:0] a;
        logic [LIMB_W-1:0] b;
    } t_mac_req;

    typedef struct packed {
        logic done;
        logic pass;
    } t_ang_res;

    function automatic t_uop f_uop(t_kind kind, t_src a, t_src b, logic [1:0] k,
                                   logic [SH_W-1:0] sh, logic sgn, logic clr, t_dst dst);
        t_uop u;
        u.kind = kind;
        u.a    = a;
        u.b    = b;
        u.k    = k;
        u.sh   = sh;
        u.sgn  = sgn;
        u.clr  = clr;
        u.dst  = dst;
        return u;
    endfunction

    // Angle test program. A save captures the accumulator once the last product
    // of its group has passed the product register and the accumulate stage.
    function automatic t_uop f_ucode(logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:  u = f_uop(K_MUL, S_UM, S_VM, 2'd0, 3'd0, 1'b1, 1'b1, D_NONE);
            5'd1:  u = f_uop(K_MUL, S_UM, S_VM, 2'd1, 3'd0, 1'b1, 1'b0, D_NONE);
            5'd2:  u = f_uop(K_MUL, S_UM, S_VM, 2'd2, 3'd0, 1'b1, 1'b0, D_NONE);
            5'd3:  u = f_uop(K_MUL, S_UM, S_UM, 2'd0, 3'd0, 1'b0, 1'b1, D_NONE);
            5'd4:  u = f_uop(K_MUL, S_UM, S_UM, 2'd1, 3'd0, 1'b0, 1'b0, D_DOT);
            5'd5:  u = f_uop(K_MUL, S_UM, S_UM, 2'd2, 3'd0, 1'b0, 1'b0, D_NONE);
            5'd6:  u = f_uop(K_MUL, S_VM, S_VM, 2'd0, 3'd0, 1'b0, 1'b1, D_NONE);
            5'd7:  u = f_uop(K_MUL, S_VM, S_VM, 2'd1, 3'd0, 1'b0, 1'b0, D_UU);
            5'd8:  u = f_uop(K_MUL, S_VM, S_VM, 2'd2, 3'd0, 1'b0, 1'b0, D_NONE);
            5'd9:  u = f_uop(K_MUL, S_T,  S_T,  2'd0, 3'd0, 1'b0, 1'b1, D_NONE);
            5'd10: u = f_uop(K_MUL, S_D0, S_D0, 2'd0, 3'd0, 1'b0, 1'b1, D_VV);
            5'd11: u = f_uop(K_MUL, S_D0, S_D1, 2'd0, 3'd1, 1'b0, 1'b0, D_TT);
            5'd12: u = f_uop(K_MUL, S_D1, S_D0, 2'd0, 3'd1, 1'b0, 1'b0, D_NONE);
            5'd13: u = f_uop(K_MUL, S_D1, S_D1, 2'd0, 3'd2, 1'b0, 1'b0, D_NONE);
            5'd14: u = f_uop(K_MUL, S_TT, S_U0, 2'd0, 3'd0, 1'b0, 1'b1, D_NONE);
            5'd15: u = f_uop(K_MUL, S_TT, S_U1, 2'd0, 3'd1, 1'b0, 1'b0, D_LHS);
            5'd16: u = f_uop(K_NOP, S_T,  S_T,  2'd0, 3'd0, 1'b0, 1'b0, D_NONE);
            5'd17: u = f_uop(K_NOP, S_T,  S_T,  2'd0, 3'd0, 1'b0, 1'b0, D_RR);
            5'd18: u = f_uop(K_MUL, S_R0, S_V0, 2'd0, 3'd0, 1'b0, 1'b1, D_NONE);
            5'd19: u = f_uop(K_MUL, S_R0, S_V1, 2'd0, 3'd1, 1'b0, 1'b0, D_NONE);
            5'd20: u = f_uop(K_MUL, S_R1, S_V0, 2'd0, 3'd1, 1'b0, 1'b0, D_NONE);
            5'd21: u = f_uop(K_MUL, S_R1, S_V1, 2'd0, 3'd2, 1'b0, 1'b0, D_NONE);
            5'd22: u = f_uop(K_MUL, S_R2, S_V0, 2'd0, 3'd2, 1'b0, 1'b0, D_NONE);
            5'd23: u = f_uop(K_MUL, S_R2, S_V1, 2'd0, 3'd3, 1'b0, 1'b0, D_NONE);
            5'd24: u = f_uop(K_NOP, S_T,  S_T,  2'd0, 3'd0, 1'b0, 1'b0, D_NONE);
            default: u = f_uop(K_DONE, S_T, S_T, 2'd0, 3'd0, 1'b0, 1'b0, D_NONE);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/avr_mac.sv
`timescale 1ns / 1ps

module avr_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  avr_pkg::t_mac_req         i_req,
    output logic [avr_pkg::ACC_W-1:0] o_acc
);
    import avr_pkg::*;

    logic                r_pv;
    logic                r_clr;
    logic                r_sub;
    logic [SH_W-1:0]     r_sh;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    w_base;
    logic [ACC_W-1:0]    w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_req.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
            r_clr  <= i_req.clr;
            r_sub  <= i_req.sub;
            r_sh   <= i_req.sh;
        end
        if (r_pv) begin
            r_acc <= n_acc;
        end
    end

    assign w_base   = r_clr ? '0 : r_acc;
    assign w_addend = ACC_W'(r_prod) << (LIMB_W * int'(r_sh));
    assign n_acc    = r_sub ? (w_base - w_addend) : (w_base + w_addend);
    assign o_acc    = r_acc;

endmodule

>>> rtl/avr_angle.sv
`timescale 1ns / 1ps

module avr_angle #(
    parameter int COORD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [avr_pkg::THR_W-1:0]         i_thr,
    input  logic [2:0][COORD_BITS-1:0]        i_anchor,
    input  logic [2:0][COORD_BITS-1:0]        i_pivot,
    input  logic [2:0][COORD_BITS-1:0]        i_cand,
    output avr_pkg::t_ang_res                 o_res
);
    import avr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam logic [1:0] K_LAST = 2'd2;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIFF,
        A_RUN
    } t_state;

    t_state              r_state;
    logic [1:0]          r_k;
    logic [PC_W-1:0]     r_pc;
    t_ang_res            r_res;

    logic [DW-1:0]       r_umag [3];
    logic [DW-1:0]       r_vmag [3];
    logic [2:0]          r_usgn;
    logic [2:0]          r_vsgn;
    logic [PROD_W-1:0]   r_dot;
    logic [PROD_W-1:0]   r_uu;
    logic [PROD_W-1:0]   r_vv;
    logic [LIMB_W-1:0]   r_tt;
    logic [4*LIMB_W-1:0] r_lhs;
    logic [3*LIMB_W-1:0] r_rr;

    t_uop                w_uop;
    t_mac_req            w_req;
    logic [ACC_W-1:0]    w_acc;
    logic [ACC_W-1:0]    w_acc_abs;
    logic [DW-1:0]       w_u;
    logic [DW-1:0]       w_v;
    logic [DW-1:0]       w_um;
    logic [DW-1:0]       w_vm;
    logic                w_less;

    function automatic logic [LIMB_W-1:0] f_opnd(t_src s);
        logic [LIMB_W-1:0] r;
        case (s)
            S_UM:    r = LIMB_W'(w_um);
            S_VM:    r = LIMB_W'(w_vm);
            S_D0:    r = r_dot[LIMB_W-1:0];
            S_D1:    r = r_dot[2*LIMB_W-1:LIMB_W];
            S_U0:    r = r_uu[LIMB_W-1:0];
            S_U1:    r = r_uu[2*LIMB_W-1:LIMB_W];
            S_V0:    r = r_vv[LIMB_W-1:0];
            S_V1:    r = r_vv[2*LIMB_W-1:LIMB_W];
            S_T:     r = LIMB_W'(i_thr);
            S_TT:    r = r_tt;
            S_R0:    r = r_rr[LIMB_W-1:0];
            S_R1:    r = r_rr[2*LIMB_W-1:LIMB_W];
            S_R2:    r = r_rr[3*LIMB_W-1:2*LIMB_W];
            default: r = '0;
        endcase
        return r;
    endfunction

    // Coordinate differences about the pivot, one axis per cycle.
    assign w_u = {i_anchor[r_k][COORD_BITS-1], i_anchor[r_k]}
               - {i_pivot[r_k][COORD_BITS-1], i_pivot[r_k]};
    assign w_v = {i_cand[r_k][COORD_BITS-1], i_cand[r_k]}
               - {i_pivot[r_k][COORD_BITS-1], i_pivot[r_k]};

    assign w_uop = f_ucode(r_pc);
    assign w_um  = r_umag[w_uop.k];
    assign w_vm  = r_vmag[w_uop.k];

    always_comb begin
        w_req.en  = (r_state == A_RUN) && (w_uop.kind == K_MUL);
        w_req.clr = w_uop.clr;
        w_req.sub = w_uop.sgn & (r_usgn[w_uop.k] ^ r_vsgn[w_uop.k]);
        w_req.sh  = w_uop.sh;
        w_req.a   = f_opnd(w_uop.a);
        w_req.b   = f_opnd(w_uop.b);
    end

    avr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_acc   (w_acc)
    );

    assign w_acc_abs = w_acc[ACC_W-1] ? (~w_acc + 1'b1) : w_acc;
    assign w_less    = (ACC_W'(r_lhs) << LHS_SHIFT) < w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_k     <= '0;
            r_pc    <= '0;
            r_res   <= '0;
        end else begin
            r_res.done <= (r_state == A_RUN) && (w_uop.kind == K_DONE);
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_state <= A_DIFF;
                        r_k     <= '0;
                    end
                end
                A_DIFF: begin
                    r_usgn[r_k] <= w_u[DW-1];
                    r_vsgn[r_k] <= w_v[DW-1];
                    r_umag[r_k] <= w_u[DW-1] ? (~w_u + 1'b1) : w_u;
                    r_vmag[r_k] <= w_v[DW-1] ? (~w_v + 1'b1) : w_v;
                    if (r_k == K_LAST) begin
                        r_state <= A_RUN;
                        r_pc    <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                A_RUN: begin
                    case (w_uop.dst)
                        D_DOT:   r_dot <= w_acc_abs[PROD_W-1:0];
                        D_UU:    r_uu  <= w_acc[PROD_W-1:0];
                        D_VV:    r_vv  <= w_acc[PROD_W-1:0];
                        D_TT:    r_tt  <= w_acc[LIMB_W-1:0];
                        D_LHS:   r_lhs <= w_acc[4*LIMB_W-1:0];
                        D_RR:    r_rr  <= w_acc[3*LIMB_W-1:0];
                        default: ;
                    endcase
                    if (w_uop.kind == K_DONE) begin
                        r_res.pass <= w_less;
                        r_state    <= A_IDLE;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/polyline_angle_vertex_reducer_core.sv
// Polyline vertex reducer.
// Input channel (i_in_valid / o_in_ready): one vertex per transaction, with the
// line tag and a flag on the last vertex of the line. Output channel
// (o_out_valid / i_out_ready): one kept vertex per transaction, tagged with the
// line's tag and flagged on the last kept vertex.
// First and last vertices, second vertices and all vertices with keep_mode 0
// are handled in idle: a kept vertex is in the output register the cycle after
// its transaction; a new vertex can then be taken unless the receiver stalls.
// An interior vertex with keep_mode 1 runs the angle test on one shared
// 34x34 multiplier with a 170-bit accumulator: a difference pass over the
// three axes, 26 microcode steps and a hand-off back to the core; the block
// is not ready during the test nor, for a kept vertex, until it is emitted.
// The configuration port writes keep_mode (index 0) and cos_threshold
// (index 1) with i_cfg_we; write only while idle.
// Reset (synchronous, active low) empties the output register, returns the
// sequencer to idle, expects the first vertex of a line and restores the
// register defaults. A stalled receiver holds the output register; input
// is taken only while that register is empty or being drained.
`timescale 1ns / 1ps

module polyline_angle_vertex_reducer_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [avr_pkg::THR_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [COORD_BITS-1:0]      i_px,
    input  logic signed [COORD_BITS-1:0]      i_py,
    input  logic signed [COORD_BITS-1:0]      i_pz,
    input  logic [avr_pkg::TAG_W-1:0]         i_line_tag,
    input  logic                              i_is_final,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [COORD_BITS-1:0]      o_qx,
    output logic signed [COORD_BITS-1:0]      o_qy,
    output logic signed [COORD_BITS-1:0]      o_qz,
    output logic [avr_pkg::TAG_W-1:0]         o_out_tag,
    output logic                              o_line_done
);
    import avr_pkg::*;

    localparam logic [1:0] VP_FIRST  = 2'd0;
    localparam logic [1:0] VP_SECOND = 2'd1;
    localparam logic [1:0] VP_LATER  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_EMIT
    } t_state;

    t_state                      r_state;
    logic [1:0]                  r_vpos;
    logic                        r_keep;
    logic [THR_W-1:0]            r_thr;
    logic [2:0][COORD_BITS-1:0]  r_anchor;
    logic [2:0][COORD_BITS-1:0]  r_pivot;
    logic [2:0][COORD_BITS-1:0]  r_cand;
    logic [TAG_W-1:0]            r_held_tag;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [2:0][COORD_BITS-1:0]  r_q;
    logic [TAG_W-1:0]            r_out_tag;
    logic                        r_line_done;

    logic [2:0][COORD_BITS-1:0]  w_p;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_start;
    t_ang_res                    w_res;

    assign w_p        = {i_pz, i_py, i_px};
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_start    = w_in_acc && (r_vpos != VP_FIRST) && (r_vpos != VP_SECOND)
                      && !i_is_final && r_keep;

    assign n_out_valid = ((r_state == ST_IDLE) && w_in_acc
                          && ((r_vpos == VP_FIRST) || i_is_final))
                       || ((r_state == ST_EMIT) && w_out_free)
                       || (r_out_valid && !i_out_ready);

    avr_angle #(
        .COORD_BITS (COORD_BITS)
    ) u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_thr    (r_thr),
        .i_anchor (r_anchor),
        .i_pivot  (r_pivot),
        .i_cand   (r_cand),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vpos      <= VP_FIRST;
            r_keep      <= 1'b0;
            r_thr       <= COS_THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEEP_MODE:     r_keep <= i_cfg_data[0];
                    CFG_COS_THRESHOLD: r_thr  <= i_cfg_data;
                endcase
            end

            r_out_valid <= n_out_valid;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (r_vpos == VP_FIRST) begin
                            r_held_tag  <= i_line_tag;
                            r_anchor    <= w_p;
                            r_q         <= w_p;
                            r_out_tag   <= i_line_tag;
                            r_line_done <= i_is_final;
                            r_vpos      <= i_is_final ? VP_FIRST : VP_SECOND;
                        end else if (i_is_final) begin
                            r_q         <= w_p;
                            r_out_tag   <= r_held_tag;
                            r_line_done <= 1'b1;
                            r_vpos      <= VP_FIRST;
                        end else if (r_vpos == VP_SECOND) begin
                            r_pivot <= w_p;
                            r_vpos  <= VP_LATER;
                        end else begin
                            r_vpos <= VP_LATER;
                            if (r_keep) begin
                                r_cand  <= w_p;
                                r_state <= ST_TEST;
                            end else begin
                                r_pivot <= w_p;
                            end
                        end
                    end
                end
                ST_TEST: begin
                    if (w_res.done) begin
                        r_pivot <= r_cand;
                        if (w_res.pass) begin
                            r_anchor <= r_pivot;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_q         <= r_cand;
                        r_out_tag   <= r_held_tag;
                        r_line_done <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_qx        = r_q[0];
    assign o_qy        = r_q[1];
    assign o_qz        = r_q[2];
    assign o_out_tag   = r_out_tag;
    assign o_line_done = r_line_done;

`ifndef SYNTH
    a_done_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == ST_TEST))
        else $error("angle result outside of test state");

    a_first_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_vpos == VP_FIRST)) |=>
            (o_out_valid && (o_out_tag == $past(i_line_tag))))
        else $error("first vertex of a line not emitted with its tag");

    a_emit_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_vpos == VP_LATER))
        else $error("interior vertex emitted outside an open line");
`endif

endmodule
